>>> design/ric_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ric_pkg
// Shared constants and types of the ring intersection components unit.
// ----------------------------------------------------------------------------
package ric_pkg;

    localparam int MAX_RINGS  = 128;
    localparam int COORD_BITS = 24;
    localparam int IDX_W      = (MAX_RINGS > 1) ? $clog2(MAX_RINGS) : 1;
    localparam int CNT_W      = $clog2(MAX_RINGS + 1);
    localparam int OUT_W      = 8;
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int SQ_W       = 2 * DIFF_W;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic [COORD_BITS-1:0]        r;
        logic [IDX_W-1:0]             label;
    } t_ring;

    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] label;
    } t_mark;

endpackage

>>> design/ric_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ric_cell
// One store cell: holds a ring, shifts from its neighbour or loads a new ring.
// ----------------------------------------------------------------------------
module ric_cell (
    input  logic           i_clk,
    input  logic           i_shift,
    input  logic           i_load,
    input  ric_pkg::t_ring i_neigh,
    input  ric_pkg::t_ring i_ring,
    output ric_pkg::t_ring o_ring
);
    ric_pkg::t_ring r_ring;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_ring <= i_ring;
        end else if (i_shift) begin
            r_ring <= i_neigh;
        end
    end

    assign o_ring = r_ring;
endmodule

>>> design/ric_meet.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ric_meet
// Three-stage intersection test of the new ring against one stored ring.
// ----------------------------------------------------------------------------
module ric_meet (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  ric_pkg::t_ring i_new,
    input  ric_pkg::t_ring i_old,
    output ric_pkg::t_mark o_mark
);
    localparam int DW = ric_pkg::DIFF_W;
    localparam int SW = ric_pkg::SQ_W;

    logic [DW-1:0]    r_dx, r_dy, r_rd, r_rs;
    logic [DW-1:0]    n_dx, n_dy, n_rd, n_rs;
    ric_pkg::t_mark   r_m1, r_m2, r_m3;
    logic [SW-1:0]    r_dx2, r_dy2, r_rd2, r_rs2;
    logic [SW:0]      w_dist;
    logic signed [DW-1:0] w_sx, w_sy;
    logic [DW-1:0]    w_ra, w_rb;

    always_comb begin
        w_sx = DW'(i_new.x) - DW'(i_old.x);
        w_sy = DW'(i_new.y) - DW'(i_old.y);
        n_dx = w_sx[DW-1] ? DW'(-w_sx) : DW'(w_sx);
        n_dy = w_sy[DW-1] ? DW'(-w_sy) : DW'(w_sy);
        w_ra = {1'b0, i_new.r};
        w_rb = {1'b0, i_old.r};
        n_rd = (w_ra > w_rb) ? (w_ra - w_rb) : (w_rb - w_ra);
        n_rs = w_ra + w_rb;
    end

    always_ff @(posedge i_clk) begin
        r_dx  <= n_dx;
        r_dy  <= n_dy;
        r_rd  <= n_rd;
        r_rs  <= n_rs;
        r_dx2 <= r_dx * r_dx;
        r_dy2 <= r_dy * r_dy;
        r_rd2 <= r_rd * r_rd;
        r_rs2 <= r_rs * r_rs;
        r_m1.label <= i_old.label;
        r_m2.label <= r_m1.label;
        r_m3.label <= r_m2.label;
        if (!i_rst_n) begin
            r_m1.valid <= 1'b0;
            r_m2.valid <= 1'b0;
            r_m3.valid <= 1'b0;
        end else begin
            r_m1.valid <= i_en;
            r_m2.valid <= r_m1.valid;
            r_m3.valid <= r_m2.valid && ({1'b0, r_rd2} <= w_dist)
                          && (w_dist <= {1'b0, r_rs2});
        end
    end

    assign w_dist = {1'b0, r_dx2} + {1'b0, r_dy2};
    assign o_mark = r_m3;
endmodule

>>> design/ring_intersection_components_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ring_intersection_components_unit
// Incremental connected components of intersecting rings.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (i_valid / o_ready) carries one ring word: new_set flag,
//    centre x/y and radius in Q16.8. Output channel (o_valid / i_ready)
//    returns one word per ring: own component size, largest size, dropped.
//  - Stored rings sit in a row of cells that rotates one place per cycle
//    during the two passes, past a three-stage intersection tester.
//  - Pass one: the row turns once round; marks touched components' labels.
//    Drain: lets the tester pipeline empty.
//    Pass two: the row turns once more; relabels and counts marked members.
//    Store: writes the new ring, then the result is registered.
//  - A ring without new_set that finds the store full is dropped and skips
//    both passes. One ring is in work at a time: the next word is taken
//    only after the result has moved to the output register.
//  - o_ready is high whenever the unit is idle, even while a result waits;
//    a finished result is held until the output register is free, so a
//    stalled receiver simply holds the unit in its final state.
//  - Reset empties the store, clears the largest size and the label marks.
//  - new_set empties the store before its own ring is added.
// ----------------------------------------------------------------------------
module ring_intersection_components_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_new_set,
    input  logic signed [ric_pkg::COORD_BITS-1:0] i_x_pos,
    input  logic signed [ric_pkg::COORD_BITS-1:0] i_y_pos,
    input  logic [ric_pkg::COORD_BITS-1:0]      i_ring_radius,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [ric_pkg::OUT_W-1:0]           o_own_size,
    output logic [ric_pkg::OUT_W-1:0]           o_largest_size,
    output logic                                o_dropped
);
    localparam int N  = ric_pkg::MAX_RINGS;
    localparam int IW = ric_pkg::IDX_W;
    localparam int CW = ric_pkg::CNT_W;
    localparam int OW = ric_pkg::OUT_W;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_PASS1 = 6'b000010,
        S_DRAIN = 6'b000100,
        S_PASS2 = 6'b001000,
        S_STORE = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state          r_state;
    logic [CW-1:0]   r_pos;      // rotation count, = original index of head
    logic [1:0]      r_drain;
    logic [CW-1:0]   r_n;        // rings stored
    logic [CW-1:0]   r_best;
    logic [CW-1:0]   r_cnt;      // members of marked components
    logic [CW-1:0]   r_size;
    logic            r_drop;
    logic [N-1:0]    r_mark;
    ric_pkg::t_ring  r_new;

    logic            r_o_valid, r_o_drop;
    logic [OW-1:0]   r_o_own, r_o_big;

    ric_pkg::t_ring  w_cell [N];
    ric_pkg::t_ring  w_wrap;
    ric_pkg::t_mark  w_mark;
    logic            w_shift, w_head_ok, w_head_mk, w_out_free;
    logic [CW-1:0]   w_size;

    assign w_shift   = (r_state == S_PASS1) || (r_state == S_PASS2);
    assign w_head_ok = r_pos < r_n;
    assign w_head_mk = r_mark[w_cell[0].label];
    assign w_out_free = !r_o_valid || i_ready;
    assign w_size    = r_cnt + CW'(1);

    // head wraps to the tail; in pass two marked members take the new label
    always_comb begin
        w_wrap = w_cell[0];
        if (r_state == S_PASS2 && w_head_ok && w_head_mk) begin
            w_wrap.label = r_n[IW-1:0];
        end
    end

    generate
        for (genvar g = 0; g < N; g++) begin : g_cell
            ric_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (w_shift),
                .i_load  (r_state == S_STORE && r_n[IW-1:0] == IW'(g)),
                .i_neigh ((g == N - 1) ? w_wrap : w_cell[(g + 1) % N]),
                .i_ring  (r_new),
                .o_ring  (w_cell[g])
            );
        end
    endgenerate

    ric_meet u_meet (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (r_state == S_PASS1 && w_head_ok),
        .i_new   (r_new),
        .i_old   (w_cell[0]),
        .o_mark  (w_mark)
    );

    assign o_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_new.x     <= i_x_pos;
            r_new.y     <= i_y_pos;
            r_new.r     <= i_ring_radius;
            // new ring's label is its store slot; a new set starts at slot 0
            r_new.label <= i_new_set ? '0 : r_n[IW-1:0];
        end
        if (r_state == S_STORE) begin
            r_size <= w_size;
        end
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pos     <= '0;
            r_drain   <= '0;
            r_n       <= '0;
            r_best    <= '0;
            r_cnt     <= '0;
            r_drop    <= 1'b0;
            r_mark    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (r_state == S_DONE && w_out_free) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
            if (w_mark.valid) begin
                r_mark[w_mark.label] <= 1'b1;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_pos <= '0;
                        r_cnt <= '0;
                        if (i_new_set) begin
                            r_n    <= '0;
                            r_best <= '0;
                            r_drop <= 1'b0;
                            r_state <= S_PASS1;
                        end else if (r_n == CW'(N)) begin
                            r_drop  <= 1'b1;
                            r_state <= S_DONE;
                        end else begin
                            r_drop  <= 1'b0;
                            r_state <= S_PASS1;
                        end
                    end
                end
                S_PASS1: begin
                    if (r_pos == CW'(N - 1)) begin
                        r_pos   <= '0;
                        r_drain <= '0;
                        r_state <= S_DRAIN;
                    end else begin
                        r_pos <= r_pos + CW'(1);
                    end
                end
                S_DRAIN: begin
                    r_drain <= r_drain + 2'd1;
                    if (r_drain == 2'd2) begin
                        r_state <= S_PASS2;
                    end
                end
                S_PASS2: begin
                    if (w_head_ok && w_head_mk) begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                    r_pos <= r_pos + CW'(1);
                    if (r_pos == CW'(N - 1)) begin
                        r_state <= S_STORE;
                    end
                end
                S_STORE: begin
                    r_mark <= '0;
                    r_n    <= r_n + CW'(1);
                    if (w_size > r_best) begin
                        r_best <= w_size;
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && w_out_free) begin
            r_o_drop <= r_drop;
            r_o_own  <= r_drop ? '0 : OW'(r_size);
            r_o_big  <= OW'(r_best);
        end
    end

    assign o_valid        = r_o_valid;
    assign o_own_size     = r_o_own;
    assign o_largest_size = r_o_big;
    assign o_dropped      = r_o_drop;
endmodule

>>> design/ric_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ric_checker
// Port-level checks of the ring intersection components unit.
// ----------------------------------------------------------------------------
module ric_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_valid,
    input logic                        i_ready,
    input logic [ric_pkg::OUT_W-1:0]   o_own_size,
    input logic [ric_pkg::OUT_W-1:0]   o_largest_size,
    input logic                        o_dropped
);
    a_drop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_dropped |-> o_own_size == '0)
        else $error("dropped word with non-zero size");

    a_size_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_dropped |-> o_own_size != '0 && o_own_size <= o_largest_size)
        else $error("own size outside 1..largest");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_own_size)
            && $stable(o_largest_size) && $stable(o_dropped))
        else $error("stalled result changed");
endmodule

bind ring_intersection_components_unit ric_checker u_ric_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_own_size     (o_own_size),
    .o_largest_size (o_largest_size),
    .o_dropped      (o_dropped)
);
